@@ src/btth_pkg.sv @@
// Package for the ballistic time-to-height solver: widths, item types and pipeline depths.
// It depends on nothing. Every other file of the block uses it.
package btth_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // c = pos - goal is one bit wider than a word.
  localparam int C_BITS   = WORD_BITS + 1;
  // Discriminant B*B - 2*A*C needs two words plus one bit.
  localparam int D_BITS   = 2 * WORD_BITS + 1;
  localparam int SQ_BITS  = (D_BITS + 1) / 2;
  localparam int SQ_PAD   = 2 * SQ_BITS;
  localparam int SQ_RW    = SQ_BITS + 3;
  // Numerators -B +/- S as signed values and their magnitudes.
  localparam int NS_BITS  = SQ_BITS + 2;
  localparam int NM_BITS  = SQ_BITS + 1;
  localparam int DIVN     = NM_BITS + FRAC_BITS;

  localparam int QDEPTH   = 4;
  localparam int QPTR     = $clog2(QDEPTH);
  localparam int QCNT     = $clog2(QDEPTH + 1);

  localparam logic [DIVN:0] LIM_POS = (DIVN + 1)'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [DIVN:0] LIM_NEG = (DIVN + 1)'(64'd1 << (WORD_BITS - 1));

  typedef logic signed [WORD_BITS-1:0] word_t;

  // One classified item between front end and back end.
  typedef struct packed {
    word_t                    vel;
    word_t                    acc;
    logic signed [C_BITS-1:0] c;
    logic                     azero;
  } fe_item_t;

  // Sideband that travels beside the square-root pipeline.
  typedef struct packed {
    logic  valid;
    logic  fail;
    word_t vel;
    word_t acc;
  } sq_side_t;

  // Sideband that travels beside the divider pipelines.
  typedef struct packed {
    logic valid;
    logic fail;
    logic neg1;
    logic neg2;
  } dv_side_t;

endpackage

@@ src/btth_if.sv @@
// Channel interfaces of the solver: the query channel and the result channel.
// Depends on btth_pkg for the field widths.
interface btth_in_if;
  logic                 valid;
  logic                 ready;
  btth_pkg::word_t      pos_y;
  btth_pkg::word_t      vel_y;
  btth_pkg::word_t      acc_y;
  btth_pkg::word_t      goal_y;
  modport source (output valid, output pos_y, output vel_y, output acc_y, output goal_y,
                  input ready);
  modport sink   (input valid, input pos_y, input vel_y, input acc_y, input goal_y,
                  output ready);
endinterface

interface btth_out_if;
  logic                 valid;
  logic                 ready;
  btth_pkg::word_t      hit_time;
  logic                 found;
  logic                 overflow;
  modport source (output valid, output hit_time, output found, output overflow,
                  input ready);
  modport sink   (input valid, input hit_time, input found, input overflow,
                  output ready);
endinterface

@@ src/btth_front.sv @@
// Front end: takes query beats, forms c = pos - goal and flags zero acceleration.
// Depends on btth_pkg and btth_in_if.
module btth_front (
  input  logic               clk,
  input  logic               rst_n,
  btth_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               q_push,
  output btth_pkg::fe_item_t q_item
);

  logic               fe_valid_r, fe_valid_nxt;
  btth_pkg::fe_item_t fe_item_r;
  logic               take;

  assign q_push      = fe_valid_r && !q_full;
  assign q_item      = fe_item_r;
  assign in_ch.ready = !fe_valid_r || !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    if (take) begin
      fe_valid_nxt = 1'b1;
    end else if (q_push) begin
      fe_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fe_item_r.vel   <= in_ch.vel_y;
      fe_item_r.acc   <= in_ch.acc_y;
      fe_item_r.c     <= {in_ch.pos_y[btth_pkg::WORD_BITS-1], in_ch.pos_y}
                       - {in_ch.goal_y[btth_pkg::WORD_BITS-1], in_ch.goal_y};
      fe_item_r.azero <= (in_ch.acc_y == '0);
    end
  end

endmodule

@@ src/btth_queue.sv @@
// Short queue between front end and back end so that each side can stall on its own.
// Depends on btth_pkg.
module btth_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  btth_pkg::fe_item_t push_item,
  input  logic               pop,
  output btth_pkg::fe_item_t head,
  output logic               full,
  output logic               empty
);

  btth_pkg::fe_item_t                 mem_r [btth_pkg::QDEPTH];
  logic [btth_pkg::QPTR-1:0]          wr_r, rd_r;
  logic [btth_pkg::QCNT-1:0]          count_r, count_nxt;

  assign full  = (count_r == btth_pkg::QCNT'(btth_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= btth_pkg::QCNT'(btth_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not rise on push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not fall on pop");

endmodule

@@ src/btth_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, floor(sqrt(d)).
// Depends on btth_pkg.
module btth_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [btth_pkg::D_BITS-1:0] d,
  output logic [btth_pkg::SQ_BITS-1:0] root
);

  localparam int N = btth_pkg::SQ_BITS;

  logic [btth_pkg::SQ_RW-1:0]  rem_r  [N];
  logic [N-1:0]                root_r [N];
  logic [btth_pkg::SQ_PAD-1:0] dsh_r  [N];

  logic [btth_pkg::SQ_RW-1:0]  rem_c  [N], rem_n [N], remw [N], trial [N];
  logic [N-1:0]                root_c [N], root_n [N];
  logic [btth_pkg::SQ_PAD-1:0] dsh_c  [N], dsh_n [N];
  logic [N-1:0]                ge;

  always_comb begin
    rem_c[0]  = '0;
    root_c[0] = '0;
    dsh_c[0]  = btth_pkg::SQ_PAD'(d);
    for (int k = 1; k < N; k++) begin
      rem_c[k]  = rem_r[k-1];
      root_c[k] = root_r[k-1];
      dsh_c[k]  = dsh_r[k-1];
    end
    // Bring down the next bit pair and try root*4+1 against the remainder.
    for (int k = 0; k < N; k++) begin
      remw[k]   = {rem_c[k][btth_pkg::SQ_RW-3:0], dsh_c[k][btth_pkg::SQ_PAD-1 -: 2]};
      trial[k]  = btth_pkg::SQ_RW'({root_c[k], 2'b01});
      ge[k]     = (remw[k] >= trial[k]);
      rem_n[k]  = ge[k] ? (remw[k] - trial[k]) : remw[k];
      root_n[k] = {root_c[k][N-2:0], ge[k]};
      dsh_n[k]  = {dsh_c[k][btth_pkg::SQ_PAD-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k]  <= rem_n[k];
        root_r[k] <= root_n[k];
        dsh_r[k]  <= dsh_n[k];
      end
    end
  end

  assign root = root_r[N-1];

endmodule

@@ src/btth_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on btth_pkg.
module btth_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [btth_pkg::DIVN-1:0]      num,
  input  logic [btth_pkg::WORD_BITS-1:0] den,
  output logic [btth_pkg::DIVN-1:0]      quo,
  output logic                           rem_nz
);

  localparam int N = btth_pkg::DIVN;
  localparam int W = btth_pkg::WORD_BITS;

  logic [W-1:0] rem_r [N], rem_c [N], rem_n [N];
  logic [W-1:0] den_r [N], den_c [N];
  logic [N-1:0] quo_r [N], quo_c [N], quo_n [N];
  logic [N-1:0] nsh_r [N], nsh_c [N], nsh_n [N];
  logic [W:0]   remw  [N];
  logic [N-1:0] ge;

  always_comb begin
    rem_c[0] = '0;
    den_c[0] = den;
    quo_c[0] = '0;
    nsh_c[0] = num;
    for (int k = 1; k < N; k++) begin
      rem_c[k] = rem_r[k-1];
      den_c[k] = den_r[k-1];
      quo_c[k] = quo_r[k-1];
      nsh_c[k] = nsh_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      remw[k]  = {rem_c[k], nsh_c[k][N-1]};
      ge[k]    = (remw[k] >= {1'b0, den_c[k]});
      rem_n[k] = ge[k] ? W'(remw[k] - {1'b0, den_c[k]}) : remw[k][W-1:0];
      quo_n[k] = {quo_c[k][N-2:0], ge[k]};
      nsh_n[k] = {nsh_c[k][N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_n[k];
        den_r[k] <= den_c[k];
        quo_r[k] <= quo_n[k];
        nsh_r[k] <= nsh_n[k];
      end
    end
  end

  assign quo    = quo_r[N-1];
  assign rem_nz = |rem_r[N-1];

endmodule

@@ src/btth_back.sv @@
// Back end: discriminant, square root, two root divisions, saturation and root choice.
// Depends on btth_pkg, btth_out_if, btth_sqrt and btth_div.
module btth_back (
  input  logic               clk,
  input  logic               rst_n,
  input  btth_pkg::fe_item_t head,
  input  logic               q_empty,
  output logic               q_pop,
  btth_out_if.source         out_ch
);

  localparam int W   = btth_pkg::WORD_BITS;
  localparam int NSQ = btth_pkg::SQ_BITS;
  localparam int NDV = btth_pkg::DIVN;

  logic en;

  // The whole pipeline advances together whenever the output register can move.
  assign en    = !out_ch.valid || out_ch.ready;
  assign q_pop = en && !q_empty;

  // Stage 0: item taken from the queue.
  logic               p0_valid_r;
  btth_pkg::fe_item_t p0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
    end else if (en) begin
      p0_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= head;
    end
  end

  // Stage 1: products B*B and |A|*|C|.
  logic [W-1:0]                   vm, am;
  logic [btth_pkg::C_BITS-1:0]    cm;
  logic                           p1_valid_r, p1_fail_r, p1_opp_r;
  logic [2*W-1:0]                 p1_vv_r;
  logic [2*W:0]                   p1_ac_r;
  btth_pkg::word_t                p1_vel_r, p1_acc_r;

  assign vm = p0_r.vel[W-1] ? W'(-p0_r.vel) : W'(p0_r.vel);
  assign am = p0_r.acc[W-1] ? W'(-p0_r.acc) : W'(p0_r.acc);
  assign cm = p0_r.c[btth_pkg::C_BITS-1] ? btth_pkg::C_BITS'(-p0_r.c)
                                         : btth_pkg::C_BITS'(p0_r.c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= p0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_vv_r  <= (2*W)'(vm) * (2*W)'(vm);
      p1_ac_r  <= (2*W+1)'(am) * (2*W+1)'(cm);
      p1_opp_r <= (p0_r.c != '0) && (p0_r.acc[W-1] != p0_r.c[btth_pkg::C_BITS-1]);
      p1_fail_r <= p0_r.azero;
      p1_vel_r <= p0_r.vel;
      p1_acc_r <= p0_r.acc;
    end
  end

  // Stage 2: discriminant D = B*B - 2*A*C, negative means no real root.
  logic [2*W+1:0]               vv_x, ac2;
  logic [btth_pkg::D_BITS-1:0]  p2_d_r;
  btth_pkg::sq_side_t           p2_side_r;
  logic                         disc_neg;

  assign vv_x     = (2*W+2)'(p1_vv_r);
  assign ac2      = {p1_ac_r, 1'b0};
  assign disc_neg = !p1_opp_r && (ac2 > vv_x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_side_r.valid <= 1'b0;
    end else if (en) begin
      p2_side_r.valid <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_d_r         <= p1_opp_r ? btth_pkg::D_BITS'(vv_x + ac2)
                                 : btth_pkg::D_BITS'(vv_x - ac2);
      p2_side_r.fail <= p1_fail_r || disc_neg;
      p2_side_r.vel  <= p1_vel_r;
      p2_side_r.acc  <= p1_acc_r;
    end
  end

  // Square root, with the sideband delayed alongside.
  logic [NSQ-1:0]     s_root;
  btth_pkg::sq_side_t sq_side_r [NSQ];

  btth_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .d    (p2_d_r),
    .root (s_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSQ; k++) begin
        sq_side_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      sq_side_r[0] <= p2_side_r;
      for (int k = 1; k < NSQ; k++) begin
        sq_side_r[k] <= sq_side_r[k-1];
      end
    end
  end

  // Stage 3: numerators -B - S and -B + S as magnitudes with result signs.
  btth_pkg::sq_side_t                 sqo;
  logic signed [btth_pkg::NS_BITS-1:0] vx, sx, n1, n2;
  logic [btth_pkg::NM_BITS-1:0]       n1m, n2m;
  logic [NDV-1:0]                     p3_num1_r, p3_num2_r;
  logic [W-1:0]                       p3_den_r;
  btth_pkg::dv_side_t                 p3_side_r;

  assign sqo = sq_side_r[NSQ-1];
  assign vx  = btth_pkg::NS_BITS'(sqo.vel);
  assign sx  = $signed({2'b00, s_root});
  assign n1  = -vx - sx;
  assign n2  = -vx + sx;
  assign n1m = n1[btth_pkg::NS_BITS-1] ? btth_pkg::NM_BITS'(-n1) : btth_pkg::NM_BITS'(n1);
  assign n2m = n2[btth_pkg::NS_BITS-1] ? btth_pkg::NM_BITS'(-n2) : btth_pkg::NM_BITS'(n2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_side_r.valid <= 1'b0;
    end else if (en) begin
      p3_side_r.valid <= sqo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_num1_r      <= {n1m, {btth_pkg::FRAC_BITS{1'b0}}};
      p3_num2_r      <= {n2m, {btth_pkg::FRAC_BITS{1'b0}}};
      p3_den_r       <= sqo.acc[W-1] ? W'(-sqo.acc) : W'(sqo.acc);
      p3_side_r.fail <= sqo.fail;
      p3_side_r.neg1 <= (n1m != '0) && (n1[btth_pkg::NS_BITS-1] != sqo.acc[W-1]);
      p3_side_r.neg2 <= (n2m != '0) && (n2[btth_pkg::NS_BITS-1] != sqo.acc[W-1]);
    end
  end

  // Two dividers run side by side.
  logic [NDV-1:0]     q1, q2;
  logic               r1nz, r2nz;
  btth_pkg::dv_side_t dv_side_r [NDV];

  btth_div u_div1 (
    .clk    (clk),
    .en     (en),
    .num    (p3_num1_r),
    .den    (p3_den_r),
    .quo    (q1),
    .rem_nz (r1nz)
  );

  btth_div u_div2 (
    .clk    (clk),
    .en     (en),
    .num    (p3_num2_r),
    .den    (p3_den_r),
    .quo    (q2),
    .rem_nz (r2nz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NDV; k++) begin
        dv_side_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      dv_side_r[0] <= p3_side_r;
      for (int k = 1; k < NDV; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // Stage 4: floor rounding for negative quotients, then saturation.
  btth_pkg::dv_side_t dvo;
  logic [NDV:0]       qa1, qa2, lim1, lim2;
  logic               sat1, sat2;
  logic [W-1:0]       m1, m2;
  logic               p4_valid_r, p4_fail_r, p4_ovf_r;
  btth_pkg::word_t    p4_t1_r, p4_t2_r;

  assign dvo  = dv_side_r[NDV-1];
  assign qa1  = {1'b0, q1} + (NDV+1)'(dvo.neg1 && r1nz);
  assign qa2  = {1'b0, q2} + (NDV+1)'(dvo.neg2 && r2nz);
  assign lim1 = dvo.neg1 ? btth_pkg::LIM_NEG : btth_pkg::LIM_POS;
  assign lim2 = dvo.neg2 ? btth_pkg::LIM_NEG : btth_pkg::LIM_POS;
  assign sat1 = (qa1 > lim1);
  assign sat2 = (qa2 > lim2);
  assign m1   = sat1 ? lim1[W-1:0] : qa1[W-1:0];
  assign m2   = sat2 ? lim2[W-1:0] : qa2[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else if (en) begin
      p4_valid_r <= dvo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_t1_r   <= dvo.neg1 ? W'(-m1) : m1;
      p4_t2_r   <= dvo.neg2 ? W'(-m2) : m2;
      p4_ovf_r  <= !dvo.fail && (sat1 || sat2);
      p4_fail_r <= dvo.fail;
    end
  end

  // Output register: smaller root if it is positive, else the larger one.
  btth_pkg::word_t t_lo, t_hi, t_pick;
  logic            t_found;
  logic            out_valid_r;
  btth_pkg::word_t out_time_r;
  logic            out_found_r, out_ovf_r;

  assign t_lo    = (p4_t1_r < p4_t2_r) ? p4_t1_r : p4_t2_r;
  assign t_hi    = (p4_t1_r < p4_t2_r) ? p4_t2_r : p4_t1_r;
  assign t_pick  = (t_lo > 0) ? t_lo : t_hi;
  assign t_found = !p4_fail_r && !t_pick[W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_time_r  <= t_found ? t_pick : '0;
      out_found_r <= t_found;
      out_ovf_r   <= p4_ovf_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit_time = out_time_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

@@ src/ballistic_time_to_height_top.sv @@
// Top level of the ballistic time-to-height solver.
// Depends on btth_pkg, the channel interfaces, btth_front, btth_queue and btth_back.

// Solves (A/2)t^2 + V t + (P - G) = 0 in signed Q16.16 for each query beat and returns
// one result beat: the earliest positive root (else the later one), a found flag and an
// overflow flag when a root saturated. A new query is taken every cycle while results
// keep draining. At the default widths a query passes through one front-end stage, the
// queue, three setup stages, a 33-stage square root (one result bit per stage), one
// numerator stage, two 50-stage dividers run in parallel (one quotient bit per stage),
// one saturation stage and the output register.
// A four-beat queue sits between the front end and the arithmetic pipeline.
module ballistic_time_to_height_top (
  input  logic         clk,
  input  logic         rst_n,
  btth_in_if.sink      in_ch,
  btth_out_if.source   out_ch
);

  logic               q_push, q_pop, q_full, q_empty;
  btth_pkg::fe_item_t q_in, q_head;

  btth_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  btth_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  btth_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
